>>> src/vc2d_pkg.sv
`default_nettype none

package vc2d_pkg;

   // request operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL = 2'd2;

   // fixed field widths
   localparam int CFG_W        = 11;
   localparam int KCFG_W       = 3;
   localparam int COEF_W       = 16;
   localparam int CIDX_IN_W    = 6;
   localparam int SUM_W        = 37;
   localparam int COORD_W      = 10;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int ROW_W        = 10;

   // reset values of the registers
   localparam logic [CFG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0]  HEIGHT_RESET = 11'd480;
   localparam logic [KCFG_W-1:0] KERNEL_RESET = 3'd3;

   // control from the top level to each cell
   typedef struct packed {
      logic rd_en;
      logic shift_en;
   } cell_ctrl_type;

   // per-request bookkeeping carried beside the datapath
   typedef struct packed {
      logic               emit;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } meta_type;

endpackage

`default_nettype wire

>>> src/vc2d_cell.sv
`default_nettype none

module vc2d_cell #(
   parameter int MAX_KERNEL = 7,
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16,
   parameter bit IS_FIRST   = 1'b0
) (
   input  wire logic                                   clock,
   input  wire vc2d_pkg::cell_ctrl_type                ctrl,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]           wr_addr,
   input  wire logic signed [PIXEL_BITS-1:0]           row_in,
   output logic signed [PIXEL_BITS-1:0]                row_out,
   input  wire logic signed [vc2d_pkg::COEF_W-1:0]     coef_row [MAX_KERNEL],
   output logic signed [PIXEL_BITS+vc2d_pkg::COEF_W+3:0] row_sum
);
   import vc2d_pkg::*;

   localparam int PROD_W = PIXEL_BITS + COEF_W;
   localparam int RSUM_W = PROD_W + 4;

   logic signed [PIXEL_BITS-1:0] taps_ff [MAX_KERNEL];
   logic signed [PROD_W-1:0]     prod_ff [MAX_KERNEL];
   logic signed [RSUM_W-1:0]     rsum_ff;
   logic signed [RSUM_W-1:0]     rsum_in;

   // line memory: delays the upstream row by one image row; the first cell passes it through
   generate
      if (IS_FIRST) begin : g_first
         assign row_out = row_in;
      end else begin : g_line
         logic signed [PIXEL_BITS-1:0] mem [MAX_WIDTH];
         logic signed [PIXEL_BITS-1:0] rd_ff;
         always_ff @(posedge clock) begin
            if (ctrl.rd_en) begin
               rd_ff <= mem[rd_addr];
            end
            if (ctrl.shift_en) begin
               mem[wr_addr] <= row_in;
            end
         end
         assign row_out = rd_ff;
      end
   endgenerate

   // shift this row's pixel into the window taps
   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         taps_ff[0] <= row_out;
         for (int t = 1; t < MAX_KERNEL; t++) begin
            taps_ff[t] <= taps_ff[t-1];
         end
      end
   end

   // multiply each tap by its coefficient; taps outside the kernel hold stale data
   always_ff @(posedge clock) begin
      for (int t = 0; t < MAX_KERNEL; t++) begin
         if (coef_row[t] == '0) begin
            prod_ff[t] <= '0;
         end else begin
            prod_ff[t] <= PROD_W'(taps_ff[t] * coef_row[t]);
         end
      end
   end

   // add the row's products
   always_comb begin
      rsum_in = '0;
      for (int t = 0; t < MAX_KERNEL; t++) begin
         rsum_in = rsum_in + RSUM_W'(prod_ff[t]);
      end
   end

   always_ff @(posedge clock) begin
      rsum_ff <= rsum_in;
   end

   assign row_sum = rsum_ff;

endmodule

`default_nettype wire

>>> src/valid_2d_convolution.sv
`default_nettype none

// channel   ports                                          direction
// request   req_valid/req_stall, operation..pixel          in
// result    rsp_valid/rsp_stall, sum, out_x, out_y, last   out
// csr       csr_write_en, csr_index, csr_write_data        in
//
// One request is taken per cycle while req_stall is low; a result passes the front stages, taps, products and row sums.
// The rate is set by the row of cells: one line memory read and one tap shift
// per cell and per pixel, with every kernel product done in parallel.
// Synchronous reset clears counters and the coefficients and returns the registers to their reset values.
// req_stall rises when the 8-entry result queue plus results in flight is full.

module valid_2d_convolution #(
   parameter int MAX_KERNEL = 7,
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_operation,
   input  wire logic [vc2d_pkg::CIDX_IN_W-1:0]       req_coef_index,
   input  wire logic signed [vc2d_pkg::COEF_W-1:0]   req_coefficient,
   input  wire logic signed [PIXEL_BITS-1:0]         req_pixel,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [vc2d_pkg::SUM_W-1:0]         rsp_sum,
   output logic [vc2d_pkg::COORD_W-1:0]              rsp_out_x,
   output logic [vc2d_pkg::COORD_W-1:0]              rsp_out_y,
   output logic                                      rsp_last_of_frame,
   input  wire logic                                 csr_write_en,
   input  wire logic [vc2d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [vc2d_pkg::CFG_W-1:0]           csr_write_data
);
   import vc2d_pkg::*;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WEFF_W  = $clog2(MAX_WIDTH + 1);
   localparam int KEFF_W  = $clog2(MAX_KERNEL + 1);
   localparam int NCOEF   = MAX_KERNEL * MAX_KERNEL;
   localparam int CIDX_W  = (NCOEF > 1) ? $clog2(NCOEF) : 1;
   localparam int RSUM_W  = PIXEL_BITS + COEF_W + 4;
   localparam int TOT_W   = RSUM_W + 4;
   localparam int NSTAGE  = 5;
   localparam int DEPTH   = 8;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = PTR_W + 1;
   localparam int OCC_W   = CNT_W + 1;

   // configuration registers and raster counters
   logic [CFG_W-1:0]  width_ff, height_ff;
   logic [KCFG_W-1:0] kernel_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [WEFF_W-1:0] w_eff;
   logic [CFG_W-1:0]  h_eff;
   logic [KEFF_W-1:0] k_eff;

   // front stage and second stage
   logic                         s1_valid_ff, s1_op_ff;
   logic [CIDX_IN_W-1:0]         s1_idx_ff;
   logic signed [COEF_W-1:0]     s1_coef_ff;
   logic signed [PIXEL_BITS-1:0] s1_pixel_ff, s2_pixel_ff;
   logic [COL_W-1:0]             s1_col_ff, s2_col_ff;
   logic                         s2_valid_ff;

   meta_type meta_ff [NSTAGE];
   meta_type meta_new;

   logic signed [COEF_W-1:0] coef_ff [NCOEF];
   logic signed [COEF_W-1:0] cm_ff [MAX_KERNEL][MAX_KERNEL];

   logic signed [PIXEL_BITS-1:0] chain [MAX_KERNEL+1];
   logic signed [RSUM_W-1:0]     rsums [MAX_KERNEL];
   cell_ctrl_type                ctrl;

   logic signed [TOT_W-1:0] total;
   logic signed [63:0]      total_ext;

   meta_type                q_meta_ff [DEPTH];
   logic signed [SUM_W-1:0] q_sum_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [OCC_W-1:0]        occupancy;
   logic                    req_take, push, pop;

   // clamp the registers to their working ranges
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WEFF_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WEFF_W'(MAX_WIDTH);
      end else begin
         w_eff = WEFF_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if (32'(height_ff) > HEIGHT_LIMIT) begin
         h_eff = CFG_W'(HEIGHT_LIMIT);
      end else begin
         h_eff = height_ff;
      end
      if (kernel_ff == '0) begin
         k_eff = KEFF_W'(1);
      end else if (32'(kernel_ff) > MAX_KERNEL) begin
         k_eff = KEFF_W'(MAX_KERNEL);
      end else begin
         k_eff = KEFF_W'(kernel_ff);
      end
   end

   assign req_take = req_valid && !req_stall;

   // position of this pixel, window origin and next position
   always_comb begin
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      col = (32'(col_ff) >= 32'(w_eff)) ? '0 : col_ff;
      row = (32'(row_ff) >= 32'(h_eff)) ? '0 : row_ff;
      meta_new.emit = (32'(w_eff) >= 32'(k_eff)) && (32'(h_eff) >= 32'(k_eff))
                      && (32'(col) + 1 >= 32'(k_eff)) && (32'(row) + 1 >= 32'(k_eff));
      meta_new.x    = COORD_W'(32'(col) + 1 - 32'(k_eff));
      meta_new.y    = COORD_W'(32'(row) + 1 - 32'(k_eff));
      meta_new.last = (32'(col) == 32'(w_eff) - 1) && (32'(row) == 32'(h_eff) - 1);
      col_in = col;
      row_in = row;
      if (32'(col) + 1 >= 32'(w_eff)) begin
         col_in = '0;
         row_in = (32'(row) + 1 >= 32'(h_eff)) ? '0 : ROW_W'(32'(row) + 1);
      end else begin
         col_in = COL_W'(32'(col) + 1);
      end
      if (!(req_take && req_operation == OP_PIXEL)) begin
         meta_new.emit = 1'b0;
      end
   end

   // registers, counters and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         kernel_ff   <= KERNEL_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int i = 0; i < NSTAGE; i++) begin
            meta_ff[i].emit <= 1'b0;
         end
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               REG_WIDTH:  width_ff  <= csr_write_data;
               REG_HEIGHT: height_ff <= csr_write_data;
               REG_KERNEL: kernel_ff <= csr_write_data[KCFG_W-1:0];
               default: ;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end else if (req_take && req_operation == OP_PIXEL) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_valid_ff     <= req_take;
         s2_valid_ff     <= s1_valid_ff && s1_op_ff == OP_PIXEL;
         meta_ff[0].emit <= meta_new.emit;
         for (int i = 1; i < NSTAGE; i++) begin
            meta_ff[i].emit <= meta_ff[i-1].emit;
         end
      end
      // advance the coordinates beside the datapath
      meta_ff[0].x    <= meta_new.x;
      meta_ff[0].y    <= meta_new.y;
      meta_ff[0].last <= meta_new.last;
      for (int i = 1; i < NSTAGE; i++) begin
         meta_ff[i].x    <= meta_ff[i-1].x;
         meta_ff[i].y    <= meta_ff[i-1].y;
         meta_ff[i].last <= meta_ff[i-1].last;
      end
   end

   // payload of the front stages
   always_ff @(posedge clock) begin
      s1_op_ff    <= req_operation;
      s1_idx_ff   <= req_coef_index;
      s1_coef_ff  <= req_coefficient;
      s1_pixel_ff <= req_pixel;
      s1_col_ff   <= col_in;
      if (req_operation == OP_PIXEL) begin
         s1_col_ff <= (32'(col_ff) >= 32'(w_eff)) ? '0 : col_ff;
      end
      s2_pixel_ff <= s1_pixel_ff;
      s2_col_ff   <= s1_col_ff;
   end

   // write a coefficient from the front stage register, behind earlier pixels
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCOEF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (s1_valid_ff && s1_op_ff == OP_LOAD && 32'(s1_idx_ff) < NCOEF) begin
         coef_ff[CIDX_W'(s1_idx_ff)] <= s1_coef_ff;
      end
   end

   // map coefficients onto cells (row age) and taps (column age)
   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
         for (int t = 0; t < MAX_KERNEL; t++) begin
            if (j < 32'(k_eff) && t < 32'(k_eff)) begin
               cm_ff[j][t] <= coef_ff[CIDX_W'((32'(k_eff) - 1 - j) * 32'(k_eff)
                                               + 32'(k_eff) - 1 - t)];
            end else begin
               cm_ff[j][t] <= '0;
            end
         end
      end
   end

   // row of cells, each holding one row of the window
   assign ctrl.rd_en    = s1_valid_ff && s1_op_ff == OP_PIXEL;
   assign ctrl.shift_en = s2_valid_ff;
   assign chain[0]      = s2_pixel_ff;

   generate
      for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
         vc2d_cell #(
            .MAX_KERNEL (MAX_KERNEL),
            .MAX_WIDTH  (MAX_WIDTH),
            .PIXEL_BITS (PIXEL_BITS),
            .IS_FIRST   (j == 0)
         ) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .rd_addr  (s1_col_ff),
            .wr_addr  (s2_col_ff),
            .row_in   (chain[j]),
            .row_out  (chain[j+1]),
            .coef_row (cm_ff[j]),
            .row_sum  (rsums[j])
         );
      end
   endgenerate

   // add the row sums of all cells
   always_comb begin
      total = '0;
      for (int j = 0; j < MAX_KERNEL; j++) begin
         total = total + TOT_W'(rsums[j]);
      end
   end
   assign total_ext = 64'(total);

   // result queue
   assign push      = meta_ff[NSTAGE-1].emit;
   assign pop       = rsp_valid && !rsp_stall;
   assign occupancy = OCC_W'(cnt_ff) + OCC_W'($countones({meta_ff[0].emit, meta_ff[1].emit,
                      meta_ff[2].emit, meta_ff[3].emit, meta_ff[4].emit}));
   assign req_stall = occupancy >= OCC_W'(DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_sum_ff[wr_ptr_ff]  <= total_ext[SUM_W-1:0];
         q_meta_ff[wr_ptr_ff] <= meta_ff[NSTAGE-1];
      end
   end

   assign rsp_valid         = cnt_ff != '0;
   assign rsp_sum           = q_sum_ff[rd_ptr_ff];
   assign rsp_out_x         = q_meta_ff[rd_ptr_ff].x;
   assign rsp_out_y         = q_meta_ff[rd_ptr_ff].y;
   assign rsp_last_of_frame = q_meta_ff[rd_ptr_ff].last;

   // queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff < CNT_W'(DEPTH) || pop))
      else $error("result queue overflow");

   // a pixel that completes a window enters the pipeline
   a_emit_tracked: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_operation == OP_PIXEL && meta_new.emit) |=> meta_ff[0].emit)
      else $error("emitting pixel lost");

   // end of frame sits at the last window column
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_frame) |-> rsp_out_x == COORD_W'(32'(w_eff) - 32'(k_eff)))
      else $error("end of frame at wrong column");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import vc2d_pkg::*;

   localparam int KMAX       = 7;
   localparam int WMAX       = 1024;
   localparam int DRAIN_WAIT = 20;
   localparam int STUCK_MAX  = 4000;

   typedef struct {
      logic               op;
      logic [5:0]         idx;
      logic signed [15:0] coef;
      logic signed [15:0] pix;
   } request_type;

   typedef struct {
      logic signed [SUM_W-1:0] sum;
      logic [COORD_W-1:0]      x;
      logic [COORD_W-1:0]      y;
      logic                    last;
   } window_sum_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = OP_LOAD;
   logic [CIDX_IN_W-1:0] req_coef_index = '0;
   logic signed [COEF_W-1:0] req_coefficient = '0;
   logic signed [15:0] req_pixel = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SUM_W-1:0] rsp_sum;
   logic [COORD_W-1:0] rsp_out_x;
   logic [COORD_W-1:0] rsp_out_y;
   logic rsp_last_of_frame;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_write_data = '0;

   valid_2d_convolution u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_coef_index(req_coef_index),
      .req_coefficient(req_coefficient), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sum(rsp_sum), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_last_of_frame(rsp_last_of_frame),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // shadow state of the convolver
   logic signed [15:0] row_ring [KMAX][WMAX];
   logic signed [15:0] kernel_coefs [KMAX*KMAX];
   int unsigned        cur_col, cur_row;
   logic [CFG_W-1:0]   width_reg, height_reg;
   logic [KCFG_W-1:0]  ksize_reg;

   request_type    pending_requests[$];
   window_sum_type sums_due[$];
   int             send_idle, recv_idle;
   int             errors = 0;
   int             stuck_cycles = 0;
   int             random_items = 0;

   initial forever #5 clock = ~clock;

   function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance the shadow convolver by one accepted request
   function automatic void convolve_request(request_type rq);
      int unsigned we, he, ke, x0, y0;
      longint acc;
      window_sum_type ws;
      we = clamp_cfg(width_reg, WMAX);
      he = clamp_cfg(height_reg, HEIGHT_LIMIT);
      ke = clamp_cfg(ksize_reg, KMAX);
      if (rq.op == OP_LOAD) begin
         if (rq.idx < KMAX*KMAX) kernel_coefs[rq.idx] = rq.coef;
         return;
      end
      if (cur_col >= we) cur_col = 0;
      if (cur_row >= he) cur_row = 0;
      row_ring[cur_row % KMAX][cur_col] = rq.pix;
      if (we >= ke && he >= ke && cur_col + 1 >= ke && cur_row + 1 >= ke) begin
         x0 = cur_col + 1 - ke;
         y0 = cur_row + 1 - ke;
         acc = 0;
         for (int r = 0; r < ke; r++)
            for (int c = 0; c < ke; c++)
               acc += longint'(kernel_coefs[r*ke+c]) *
                      longint'(row_ring[(y0+r) % KMAX][x0+c]);
         ws.sum  = acc[SUM_W-1:0];
         ws.x    = x0[COORD_W-1:0];
         ws.y    = y0[COORD_W-1:0];
         ws.last = (cur_col == we - 1 && cur_row == he - 1);
         sums_due.push_back(ws);
      end
      cur_col++;
      if (cur_col >= we) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= he) cur_row = 0;
      end
   endfunction

   // request driver: hold while stalled, advance on acceptance
   always @(posedge clock) begin
      request_type rq;
      if (!reset) begin
         if (req_valid && !req_stall) convolve_request(pending_requests.pop_front());
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
               rq = pending_requests[0];
               req_operation   <= rq.op;
               req_coef_index  <= rq.idx;
               req_coefficient <= rq.coef;
               req_pixel       <= rq.pix;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      window_sum_type ws;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (sums_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result sum=%0d x=%0d y=%0d last=%0b", $time,
                        rsp_sum, rsp_out_x, rsp_out_y, rsp_last_of_frame);
            end else begin
               ws = sums_due.pop_front();
               if (rsp_sum !== ws.sum) begin
                  errors++;
                  $display("%0t: sum expected %0d actual %0d", $time, ws.sum, rsp_sum);
               end
               if (rsp_out_x !== ws.x) begin
                  errors++;
                  $display("%0t: out_x expected %0d actual %0d", $time, ws.x, rsp_out_x);
               end
               if (rsp_out_y !== ws.y) begin
                  errors++;
                  $display("%0t: out_y expected %0d actual %0d", $time, ws.y, rsp_out_y);
               end
               if (rsp_last_of_frame !== ws.last) begin
                  errors++;
                  $display("%0t: last_of_frame expected %0b actual %0b", $time,
                           ws.last, rsp_last_of_frame);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // watchdog: count cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (!reset) begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_MAX) begin
            $display("** valid_2d_convolution: FAILED **");
            $finish;
         end
      end
   end

   function automatic logic signed [15:0] pick16();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void push_load(int idx, logic signed [15:0] coef);
      request_type rq;
      rq.op = OP_LOAD; rq.idx = 6'(idx); rq.coef = coef; rq.pix = 16'($urandom);
      pending_requests.push_back(rq);
   endfunction

   function automatic void push_pixel(logic signed [15:0] pix);
      request_type rq;
      rq.op = OP_PIXEL; rq.idx = 6'($urandom); rq.coef = 16'($urandom); rq.pix = pix;
      pending_requests.push_back(rq);
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         REG_WIDTH:  width_reg = data;
         REG_HEIGHT: height_reg = data;
         REG_KERNEL: ksize_reg = data[KCFG_W-1:0];
         default: ;
      endcase
      cur_col = 0;
      cur_row = 0;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // wait until every request is taken and every sum has arrived
   task automatic drain();
      while (req_valid || pending_requests.size() > 0 || sums_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // one setting: registers, a kernel load, then frames of pixels
   task automatic run_frames(int w, int h, int k, int frames, int extra, bit worst);
      int we, he, ke, n;
      drain();
      csr_write(REG_WIDTH, CFG_W'(w));
      csr_write(REG_HEIGHT, CFG_W'(h));
      csr_write(REG_KERNEL, CFG_W'(k));
      if ($urandom_range(3) == 0) csr_write(2'd3, CFG_W'($urandom));
      we = clamp_cfg(w, WMAX);
      he = clamp_cfg(h, HEIGHT_LIMIT);
      ke = clamp_cfg(k, KMAX);
      for (int i = 0; i < ke*ke; i++) push_load(i, worst ? 16'sh8000 : pick16());
      if (!worst) begin
         push_load($urandom_range(63), pick16());
         push_load($urandom_range(63), pick16());
      end
      n = frames * we * he + extra;
      for (int i = 0; i < n; i++) push_pixel(worst ? 16'sh8000 : pick16());
      random_items += n + ke*ke;
   endtask

   initial begin
      int mode;
      for (int i = 0; i < KMAX*KMAX; i++) kernel_coefs[i] = '0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      ksize_reg  = KERNEL_RESET;
      cur_col = 0;
      cur_row = 0;
      send_idle = 8;
      recv_idle = 72;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: loads under reset settings, ignored indexes, extreme pixels
      push_load(0, 16'sh7fff);
      push_load(63, 16'sh1234);
      push_load(49, 16'sh4321);
      drain();
      csr_write(REG_WIDTH, CFG_W'(3));
      csr_write(REG_HEIGHT, CFG_W'(2));
      csr_write(REG_KERNEL, CFG_W'(2));
      push_load(0, 16'sh8000);
      push_load(1, 16'sh7fff);
      push_load(2, 16'sh8000);
      push_load(3, 16'sh0001);
      push_pixel(16'sh8000); push_pixel(16'sh7fff); push_pixel(16'sh8000);
      push_pixel(16'sh8000); push_pixel(16'sh0000); push_pixel(16'sh7fff);
      push_pixel(16'shffff); push_pixel(16'sh0001);

      // extremes: largest kernel and magnitude, out-of-range width and height
      run_frames(7, 7, 7, 1, 0, 1'b1);
      run_frames(2047, 2047, 1, 0, 40, 1'b0);
      run_frames(0, 2047, 1, 0, 40, 1'b0);
      run_frames(0, 0, 0, 2, 0, 1'b0);
      run_frames(2, 5, 7, 1, 3, 1'b0);
      random_items = 0;

      // random settings, switching idle profile by progress
      while (random_items < 1000) begin
         mode = random_items * 3 / 1000;
         send_idle = (mode == 0) ? 8 : (mode == 1) ? 72 : 0;
         recv_idle = (mode == 0) ? 72 : (mode == 1) ? 8 : 0;
         run_frames($urandom_range(12), $urandom_range(9), $urandom_range(7),
                    $urandom_range(1, 3), $urandom_range(1) ? $urandom_range(5) : 0,
                    1'b0);
      end
      drain();
      if (errors == 0)
         $display("** valid_2d_convolution: PASSED **");
      else
         $display("** valid_2d_convolution: FAILED **");
      $finish;
   end

endmodule
